// ===== src/pulse_beat_detector_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PULSE_BEAT_DETECTOR_DEFINES_SVH
`define PULSE_BEAT_DETECTOR_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define PBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked through reset.
`define PBD_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pbd_pkg.sv =====
package pbd_pkg;

  typedef logic signed [15:0] sample_t;

  localparam int SAMPLE_W   = 16;
  localparam int SWING_W    = 15;
  localparam int DC_W       = 32;
  localparam int DC_FRAC    = 15;
  localparam int DC_LEAK    = 4;
  localparam int FIR_LEN    = 23;
  localparam int FIR_CENTER = 11;
  localparam int FIR_SHIFT  = 15;
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 2;

  typedef sample_t tap_line_t [0:FIR_LEN-1];

  // half of the symmetric impulse response, center tap last
  localparam logic [12:0] FIR_COEF [0:FIR_CENTER] = '{
    13'd172, 13'd321, 13'd579, 13'd927, 13'd1360, 13'd1858,
    13'd2390, 13'd2916, 13'd3391, 13'd3768, 13'd4012, 13'd4096
  };

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SWING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SWING = 2'd1;

  localparam logic [SWING_W-1:0] MIN_SWING_RST = 15'd20;
  localparam logic [SWING_W-1:0] MAX_SWING_RST = 15'd1000;

  typedef struct packed {
    logic load;
    logic drain;
  } stage_ctl_t;

endpackage

// ===== src/pbd_sample_if.sv =====
interface pbd_sample_if import pbd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== src/pbd_result_if.sv =====
interface pbd_result_if import pbd_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    beat;
  sample_t filtered;

  modport source (output valid, output beat, output filtered, input ready);
  modport sink (input valid, input beat, input filtered, output ready);
endinterface

// ===== src/pulse_beat_detector.sv =====
// Heart beat detector for an optical pulse sensor. Each sample word is
// DC-stripped by a Q15 leaky average (leak shift 4), low-pass filtered by a
// 23-tap symmetric FIR and tracked for peak and trough; a beat is flagged at
// an upward zero crossing whose peak-to-trough swing lies strictly between
// min_swing and max_swing. One sample is accepted every cycle while the result
// register is not stalled, and one result word comes out per sample: the accept
// edge updates the DC average and shifts the delay line, then the FIR sum and the
// edge tracking are registered into the result register. The result
// register stalls the front only when it is full and not taken.
module pulse_beat_detector import pbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SWING_W-1:0]   cfg_data,
  pbd_sample_if.sink           samples,
  pbd_result_if.source         results
);

  stage_ctl_t ctl;
  logic       busy;
  logic       advance;
  tap_line_t  taps;
  sample_t    level;
  logic       out_valid;
  logic       out_beat;
  sample_t    out_filtered;

  // drain the tap stage into the result register when it is free or leaving
  assign advance       = busy && (!out_valid || results.ready);
  assign samples.ready = !busy || advance;
  assign ctl.load      = samples.valid && samples.ready;
  assign ctl.drain     = advance;

  pbd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (samples.sample),
    .busy   (busy),
    .taps   (taps)
  );

  pbd_fir u_fir (
    .taps     (taps),
    .filtered (level)
  );

  pbd_track u_track (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .advance      (advance),
    .out_ready    (results.ready),
    .level        (level),
    .out_valid    (out_valid),
    .out_beat     (out_beat),
    .out_filtered (out_filtered)
  );

  assign results.valid    = out_valid;
  assign results.beat     = out_beat;
  assign results.filtered = out_filtered;

endmodule

// ===== src/pbd_front.sv =====
module pbd_front import pbd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  stage_ctl_t          ctl,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                busy,
  output tap_line_t           taps
);

  logic [DC_W-1:0]       dc_level;
  logic [DC_W-1:0]       dc_level_next;
  logic signed [DC_W:0]  dc_diff;
  logic signed [DC_W:0]  dc_step;
  logic [SAMPLE_W-1:0]   dc_est;
  sample_t               ac_value;
  logic                  busy_next;

  // leaky average in Q15: dc += floor((s<<15 - dc) / 16)
  always_comb begin
    dc_diff       = $signed({2'b00, sample, {DC_FRAC{1'b0}}}) - $signed({1'b0, dc_level});
    dc_step       = dc_diff >>> DC_LEAK;
    dc_level_next = dc_level + dc_step[DC_W-1:0];
    dc_est        = dc_level_next[DC_FRAC +: SAMPLE_W];
    ac_value      = sample_t'(sample - dc_est);
  end

  always_comb begin
    busy_next = busy;
    if (ctl.load) begin
      busy_next = 1'b1;
    end else if (ctl.drain) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      dc_level <= '0;
      for (int k = 0; k < FIR_LEN; k++) begin
        taps[k] <= '0;
      end
    end else begin
      busy <= busy_next;
      if (ctl.load) begin
        dc_level <= dc_level_next;
        taps[0]  <= ac_value;
        for (int k = 1; k < FIR_LEN; k++) begin
          taps[k] <= taps[k-1];
        end
      end
    end
  end

endmodule

// ===== src/pbd_fir.sv =====
module pbd_fir import pbd_pkg::*; (
  input  tap_line_t taps,
  output sample_t   filtered
);

  logic signed [ACC_W-1:0] prod [0:FIR_CENTER];
  logic signed [ACC_W-1:0] acc;

  // fold the symmetric taps, then one constant product per pair
  always_comb begin
    logic signed [SAMPLE_W:0] pair;
    for (int i = 0; i < FIR_CENTER; i++) begin
      pair    = (SAMPLE_W+1)'(taps[i]) + (SAMPLE_W+1)'(taps[FIR_LEN-1-i]);
      prod[i] = ACC_W'(pair) * $signed({{(ACC_W-13){1'b0}}, FIR_COEF[i]});
    end
    prod[FIR_CENTER] = ACC_W'(taps[FIR_CENTER])
                       * $signed({{(ACC_W-13){1'b0}}, FIR_COEF[FIR_CENTER]});
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i <= FIR_CENTER; i++) begin
      acc = acc + prod[i];
    end
  end

  // floor shift by 15 then wrap to 16 bits
  assign filtered = acc[FIR_SHIFT +: SAMPLE_W];

endmodule

// ===== src/pbd_track.sv =====
module pbd_track import pbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SWING_W-1:0]   cfg_data,
  input  logic                 advance,
  input  logic                 out_ready,
  input  sample_t              level,
  output logic                 out_valid,
  output logic                 out_beat,
  output sample_t              out_filtered
);

  logic [SWING_W-1:0] min_swing;
  logic [SWING_W-1:0] max_swing;

  sample_t current_level;
  sample_t running_peak;
  sample_t running_trough;
  logic    rising_flag;
  logic    falling_flag;

  sample_t running_peak_next;
  sample_t running_trough_next;
  logic    rising_flag_next;
  logic    falling_flag_next;
  logic    beat_next;

  logic                 cross_up;
  logic                 cross_down;
  logic signed [SAMPLE_W:0] swing;

  always_comb begin
    cross_up   = current_level[SAMPLE_W-1] && !level[SAMPLE_W-1];
    cross_down = (current_level > 0) && (level <= 0);
    // swing is taken at 17 bits, never wrapped
    swing      = (SAMPLE_W+1)'(running_peak) - (SAMPLE_W+1)'(running_trough);
    beat_next  = cross_up
                 && (swing > $signed({2'b00, min_swing}))
                 && (swing < $signed({2'b00, max_swing}));

    rising_flag_next    = rising_flag;
    falling_flag_next   = falling_flag;
    running_peak_next   = running_peak;
    running_trough_next = running_trough;
    if (cross_up) begin
      rising_flag_next  = 1'b1;
      falling_flag_next = 1'b0;
      running_peak_next = '0;
    end
    if (cross_down) begin
      rising_flag_next    = 1'b0;
      falling_flag_next   = 1'b1;
      running_trough_next = '0;
    end
    if (rising_flag_next && (level > current_level)) begin
      running_peak_next = level;
    end
    if (falling_flag_next && (level < current_level)) begin
      running_trough_next = level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_swing <= MIN_SWING_RST;
      max_swing <= MAX_SWING_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_SWING: min_swing <= cfg_data;
        REG_MAX_SWING: max_swing <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      current_level  <= '0;
      running_peak   <= '0;
      running_trough <= '0;
      rising_flag    <= 1'b0;
      falling_flag   <= 1'b0;
    end else if (advance) begin
      out_valid      <= 1'b1;
      current_level  <= level;
      running_peak   <= running_peak_next;
      running_trough <= running_trough_next;
      rising_flag    <= rising_flag_next;
      falling_flag   <= falling_flag_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result word, held until taken
  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat     <= beat_next;
      out_filtered <= level;
    end
  end

endmodule

// ===== src/pbd_checker.sv =====
`include "pulse_beat_detector_defines.svh"

module pbd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_beat,
  input logic [15:0] out_filtered
);

  `PBD_ASSERT_NEXT(a_rst_clears, clk, rst, !out_valid, "result valid after reset")
  `PBD_ASSERT_NOW(a_out_hold, clk, rst, $past(out_valid && !out_ready) && !$past(rst), out_valid, "result word dropped while stalled")
  `PBD_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready, "input stalled with empty result register")
  `PBD_ASSERT_NOW(a_beat_sign, clk, rst, out_valid && out_beat, !out_filtered[15], "beat on a negative filtered value")

endmodule

bind pulse_beat_detector pbd_checker u_pbd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (samples.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_beat     (results.beat),
  .out_filtered (results.filtered)
);
